@@ rtl/priority_bitmap_task_scheduler_assert.svh @@
// assertion macros for the priority bitmap task scheduler
// used by the port checker; no other dependencies
`ifndef PRIORITY_BITMAP_TASK_SCHEDULER_ASSERT_SVH
`define PRIORITY_BITMAP_TASK_SCHEDULER_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define PBTS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pbts assertion failed");

// next-cycle implication, disabled while reset is low
`define PBTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pbts assertion failed");

`endif

@@ rtl/pbts_pkg.sv @@
// shared types and codes for the priority bitmap task scheduler
// no dependencies
`default_nettype none

package pbts_pkg;

    typedef enum logic [1:0] {
        OP_CREATE   = 2'd0,
        OP_TICK     = 2'd1,
        OP_DELAY    = 2'd2,
        OP_DISPATCH = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_BAD_PRIO = 3'd2,
        ST_NO_CUR   = 3'd3,
        ST_NO_RUN   = 3'd4
    } t_status;

    localparam int unsigned PRIO_W  = 8;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned INDEX_W = 3;

    typedef struct packed {
        t_op                op;
        logic               prio_bad;
        logic [PRIO_W-1:0]  prio;
        logic [TIME_W-1:0]  wake;
    } t_cmd;

endpackage

`default_nettype wire

@@ rtl/priority_bitmap_task_scheduler.sv @@
// channel   direction  handshake            payload
// command   in         start, busy          i_op i_task_prio i_base_time i_period
// result    out        o_done (one cycle)   o_status ... o_tick_value
//
// create, delay and dispatch pass through the queue register and the result register to
// o_done; a tick also walks the created tasks, one task a cycle, before the pick state.
// the two-entry queue takes up to two commands ahead; busy is high while it is full.
// i_rst_n is synchronous, active low, and clears the control state; task tables are not reset.
// the receiver cannot stall; o_done is high for one cycle per result.
// top level; depends on pbts_pkg, pbts_front, pbts_queue, pbts_back
`default_nettype none

module priority_bitmap_task_scheduler #(
    parameter int unsigned TASK_COUNT = 8,
    parameter int unsigned PRIO_COUNT = 8
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [1:0]                    i_op,
    input  wire logic [pbts_pkg::PRIO_W-1:0]   i_task_prio,
    input  wire logic [pbts_pkg::TIME_W-1:0]   i_base_time,
    input  wire logic [pbts_pkg::TIME_W-1:0]   i_period,
    output logic                               o_done,
    output logic [2:0]                         o_status,
    output logic [pbts_pkg::INDEX_W-1:0]       o_task_index,
    output logic                               o_need_switch,
    output logic [pbts_pkg::TIME_W-1:0]        o_wake_time,
    output logic [pbts_pkg::INDEX_W-1:0]       o_current_index,
    output logic                               o_current_valid,
    output logic [pbts_pkg::TIME_W-1:0]        o_tick_value
);

    logic           q_full, q_valid, push, pop;
    pbts_pkg::t_cmd f_cmd, q_cmd;

    pbts_front #(
        .PRIO_COUNT(PRIO_COUNT)
    ) u_front (
        .start       (start),
        .busy        (busy),
        .i_op        (i_op),
        .i_task_prio (i_task_prio),
        .i_base_time (i_base_time),
        .i_period    (i_period),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_cmd       (f_cmd)
    );

    pbts_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (f_cmd),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_cmd   (q_cmd)
    );

    pbts_back #(
        .TASK_COUNT(TASK_COUNT),
        .PRIO_COUNT(PRIO_COUNT)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .i_cmd           (q_cmd),
        .o_pop           (pop),
        .o_done          (o_done),
        .o_status        (o_status),
        .o_task_index    (o_task_index),
        .o_need_switch   (o_need_switch),
        .o_wake_time     (o_wake_time),
        .o_current_index (o_current_index),
        .o_current_valid (o_current_valid),
        .o_tick_value    (o_tick_value)
    );

endmodule

`default_nettype wire

@@ rtl/pbts_front.sv @@
// front end: accepts commands, checks priority, forms the wake sum
// depends on pbts_pkg
`default_nettype none

module pbts_front #(
    parameter int unsigned PRIO_COUNT = 8
) (
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [1:0]                    i_op,
    input  wire logic [pbts_pkg::PRIO_W-1:0]   i_task_prio,
    input  wire logic [pbts_pkg::TIME_W-1:0]   i_base_time,
    input  wire logic [pbts_pkg::TIME_W-1:0]   i_period,
    input  wire logic                          i_q_full,
    output logic                               o_push,
    output pbts_pkg::t_cmd                     o_cmd
);

    assign busy   = i_q_full;
    assign o_push = start && !i_q_full;

    always_comb begin
        o_cmd.op       = pbts_pkg::t_op'(i_op);
        o_cmd.prio     = i_task_prio;
        o_cmd.prio_bad = (i_task_prio >= pbts_pkg::PRIO_W'(PRIO_COUNT));
        o_cmd.wake     = i_base_time + i_period;
    end

endmodule

`default_nettype wire

@@ rtl/pbts_queue.sv @@
// two-entry command queue between front end and execution unit
// depends on pbts_pkg
`default_nettype none

module pbts_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire pbts_pkg::t_cmd  i_cmd,
    input  wire logic            i_pop,
    output logic                 o_valid,
    output logic                 o_full,
    output pbts_pkg::t_cmd       o_cmd
);

    pbts_pkg::t_cmd r_mem [2];
    logic           r_wr;
    logic           r_rd;
    logic [1:0]     r_cnt;

    assign o_valid = (r_cnt != 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wr <= ~r_wr;
            if (i_pop)  r_rd <= ~r_rd;
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_cmd;
    end

endmodule

`default_nettype wire

@@ rtl/pbts_back.sv @@
// execution unit: task table, ready slots, tick walk and dispatch
// depends on pbts_pkg
`default_nettype none

module pbts_back #(
    parameter int unsigned TASK_COUNT = 8,
    parameter int unsigned PRIO_COUNT = 8
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_q_valid,
    input  wire pbts_pkg::t_cmd                 i_cmd,
    output logic                                o_pop,
    output logic                                o_done,
    output logic [2:0]                          o_status,
    output logic [pbts_pkg::INDEX_W-1:0]        o_task_index,
    output logic                                o_need_switch,
    output logic [pbts_pkg::TIME_W-1:0]         o_wake_time,
    output logic [pbts_pkg::INDEX_W-1:0]        o_current_index,
    output logic                                o_current_valid,
    output logic [pbts_pkg::TIME_W-1:0]         o_tick_value
);

    localparam int unsigned TW = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;
    localparam int unsigned PW = (PRIO_COUNT > 1) ? $clog2(PRIO_COUNT) : 1;
    localparam int unsigned CW = $clog2(TASK_COUNT + 1);

    typedef enum logic [1:0] {S_IDLE, S_WALK, S_PICK} t_state;

    t_state                    r_state, n_state;
    logic [pbts_pkg::TIME_W-1:0] r_tick, n_tick;
    logic [CW-1:0]             r_total, n_total;
    logic [TASK_COUNT-1:0]     r_blocked, n_blocked;
    logic [PRIO_COUNT-1:0]     r_svalid, n_svalid;
    logic [PRIO_COUNT-1:0]     r_ready, n_ready;
    logic [TW-1:0]             r_run, n_run;
    logic                      r_run_v, n_run_v;
    logic                      r_sw, n_sw;
    logic [TW-1:0]             r_idx, n_idx;

    logic [PW-1:0]             r_prio  [TASK_COUNT];
    logic [pbts_pkg::TIME_W-1:0] r_wake [TASK_COUNT];
    logic [TW-1:0]             r_owner [PRIO_COUNT];

    logic                      emit;
    pbts_pkg::t_status         e_status;
    logic [TW-1:0]             e_idx;
    logic [pbts_pkg::TIME_W-1:0] e_wake;

    logic                      best_have;
    logic [PW-1:0]             best_p;
    logic [TW-1:0]             prio_addr;
    logic [PW-1:0]             prio_rd;
    logic [PW-1:0]             owner_addr;
    logic [TW-1:0]             owner_rd;
    logic [pbts_pkg::TIME_W-1:0] wake_rd;
    logic [pbts_pkg::TIME_W-1:0] wake_diff;
    logic                      due;
    logic [PW-1:0]             cmd_p;
    logic [TW-1:0]             new_idx;

    logic                      w_create, w_delay, w_wakeup;

    // highest ready priority
    always_comb begin
        best_have = 1'b0;
        best_p    = '0;
        for (int p = 0; p < PRIO_COUNT; p++) begin
            if (r_ready[p]) begin
                best_have = 1'b1;
                best_p    = PW'(p);
            end
        end
    end

    assign prio_addr  = (r_state == S_WALK) ? r_idx : r_run;
    assign prio_rd    = r_prio[prio_addr];
    assign owner_addr = (r_state == S_IDLE && i_cmd.op == pbts_pkg::OP_DELAY) ? prio_rd : best_p;
    assign owner_rd   = r_owner[owner_addr];
    assign wake_rd    = r_wake[r_idx];
    assign wake_diff  = r_tick - wake_rd;
    assign due        = r_blocked[r_idx] && !wake_diff[pbts_pkg::TIME_W-1];
    assign cmd_p      = i_cmd.prio[PW-1:0];
    assign new_idx    = r_total[TW-1:0];
    assign o_pop      = (r_state == S_IDLE) && i_q_valid;

    always_comb begin
        n_state   = r_state;
        n_tick    = r_tick;
        n_total   = r_total;
        n_blocked = r_blocked;
        n_svalid  = r_svalid;
        n_ready   = r_ready;
        n_run     = r_run;
        n_run_v   = r_run_v;
        n_sw      = r_sw;
        n_idx     = r_idx;
        emit      = 1'b0;
        e_status  = pbts_pkg::ST_OK;
        e_idx     = '0;
        e_wake    = '0;
        w_create  = 1'b0;
        w_delay   = 1'b0;
        w_wakeup  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    case (i_cmd.op)
                        pbts_pkg::OP_CREATE: begin
                            emit = 1'b1;
                            if (r_total >= CW'(TASK_COUNT)) begin
                                e_status = pbts_pkg::ST_FULL;
                            end else if (i_cmd.prio_bad) begin
                                e_status = pbts_pkg::ST_BAD_PRIO;
                            end else begin
                                w_create           = 1'b1;
                                e_idx              = new_idx;
                                n_total            = r_total + CW'(1);
                                n_svalid[cmd_p]    = 1'b1;
                                n_ready[cmd_p]     = 1'b1;
                                n_blocked[new_idx] = 1'b0;
                            end
                        end
                        pbts_pkg::OP_TICK: begin
                            n_tick  = r_tick + pbts_pkg::TIME_W'(1);
                            n_idx   = '0;
                            n_state = (r_total == '0) ? S_PICK : S_WALK;
                        end
                        pbts_pkg::OP_DELAY: begin
                            emit = 1'b1;
                            if (!r_run_v) begin
                                e_status = pbts_pkg::ST_NO_CUR;
                            end else begin
                                w_delay          = 1'b1;
                                e_wake           = i_cmd.wake;
                                n_blocked[r_run] = 1'b1;
                                if (r_svalid[prio_rd] && owner_rd == r_run) begin
                                    n_svalid[prio_rd] = 1'b0;
                                end
                                n_ready[prio_rd] = 1'b0;
                                n_sw             = 1'b1;
                            end
                        end
                        default: begin
                            emit = 1'b1;
                            if (best_have) begin
                                n_run   = owner_rd;
                                n_run_v = 1'b1;
                            end else if (!r_run_v) begin
                                e_status = pbts_pkg::ST_NO_RUN;
                            end
                            n_sw = 1'b0;
                        end
                    endcase
                end
            end
            S_WALK: begin
                if (due) begin
                    w_wakeup         = 1'b1;
                    n_svalid[prio_rd] = 1'b1;
                    n_ready[prio_rd]  = 1'b1;
                    n_blocked[r_idx]  = 1'b0;
                end
                if ((CW'(r_idx) + CW'(1)) == r_total) begin
                    n_state = S_PICK;
                end else begin
                    n_idx = r_idx + TW'(1);
                end
            end
            S_PICK: begin
                emit    = 1'b1;
                n_state = S_IDLE;
                if (best_have && (!r_run_v || owner_rd != r_run)) begin
                    n_sw = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_tick    <= '0;
            r_total   <= '0;
            r_blocked <= '0;
            r_svalid  <= '0;
            r_ready   <= '0;
            r_run     <= '0;
            r_run_v   <= 1'b0;
            r_sw      <= 1'b0;
            r_idx     <= '0;
            o_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_tick    <= n_tick;
            r_total   <= n_total;
            r_blocked <= n_blocked;
            r_svalid  <= n_svalid;
            r_ready   <= n_ready;
            r_run     <= n_run;
            r_run_v   <= n_run_v;
            r_sw      <= n_sw;
            r_idx     <= n_idx;
            o_done    <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            o_status        <= e_status;
            o_task_index    <= pbts_pkg::INDEX_W'(e_idx);
            o_need_switch   <= n_sw;
            o_wake_time     <= e_wake;
            o_current_index <= pbts_pkg::INDEX_W'(n_run);
            o_current_valid <= n_run_v;
            o_tick_value    <= n_tick;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_create) begin
            r_prio[new_idx] <= cmd_p;
            r_wake[new_idx] <= '0;
            r_owner[cmd_p]  <= new_idx;
        end
        if (w_delay) begin
            r_wake[r_run] <= i_cmd.wake;
        end
        if (w_wakeup) begin
            r_owner[prio_rd] <= r_idx;
        end
    end

endmodule

`default_nettype wire

@@ rtl/pbts_chk.sv @@
// port checker for the priority bitmap task scheduler, with its bind
// depends on pbts_pkg and priority_bitmap_task_scheduler_assert.svh
`default_nettype none
`include "priority_bitmap_task_scheduler_assert.svh"

module pbts_chk (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         o_done,
    input wire logic [2:0]                   o_status,
    input wire logic [pbts_pkg::INDEX_W-1:0] o_task_index,
    input wire logic [pbts_pkg::TIME_W-1:0]  o_wake_time,
    input wire logic                         o_current_valid
);

    `PBTS_ASSERT_IMPLY(a_wake_only_ok, i_clk, i_rst_n, o_done && o_status != pbts_pkg::ST_OK, o_wake_time == '0)
    `PBTS_ASSERT_IMPLY(a_index_only_ok, i_clk, i_rst_n, o_done && o_task_index != '0, o_status == pbts_pkg::ST_OK)
    `PBTS_ASSERT_IMPLY(a_no_run_idle, i_clk, i_rst_n, o_done && o_status == pbts_pkg::ST_NO_RUN, !o_current_valid)
    `PBTS_ASSERT_IMPLY(a_no_cur_idle, i_clk, i_rst_n, o_done && o_status == pbts_pkg::ST_NO_CUR, !o_current_valid)

endmodule

bind priority_bitmap_task_scheduler pbts_chk u_pbts_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_done          (o_done),
    .o_status        (o_status),
    .o_task_index    (o_task_index),
    .o_wake_time     (o_wake_time),
    .o_current_valid (o_current_valid)
);

`default_nettype wire
